// ----- rtl/bspa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer slot pool allocator package
// Field widths, operation and status codes, and the result word type.
// ----------------------------------------------------------------------------
package bspa_pkg;

   localparam int OP_W      = 1;
   localparam int SLOT_W    = 4;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 32;
   localparam int CREATED_W = 5;

   localparam logic [OP_W-1:0] OP_GET    = 1'b0;
   localparam logic [OP_W-1:0] OP_RETURN = 1'b1;

   localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RETURNED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FOREIGN   = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SLOT_W-1:0]    granted_slot;
      logic [COUNT_W-1:0]   reuse_count;
      logic [COUNT_W-1:0]   create_count;
      logic [CREATED_W-1:0] slots_created;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/bspa_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one get or return request per word.
// ----------------------------------------------------------------------------
interface bspa_req_if
   import bspa_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [SLOT_W-1:0] slot_index;

   modport source (output valid, output operation, output slot_index, input ready);
   modport sink   (input valid, input operation, input slot_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/bspa_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one allocator result per word.
// ----------------------------------------------------------------------------
interface bspa_rsp_if
   import bspa_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [SLOT_W-1:0]    granted_slot;
   logic [COUNT_W-1:0]   reuse_count;
   logic [COUNT_W-1:0]   create_count;
   logic [CREATED_W-1:0] slots_created;

   modport source (output valid, output status, output granted_slot, output reuse_count,
                   output create_count, output slots_created, input ready);
   modport sink   (input valid, input status, input granted_slot, input reuse_count,
                   input create_count, input slots_created, output ready);
endinterface
`default_nettype wire

// ----- rtl/bspa_first_free.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lowest free slot finder
// Priority encoder that returns the index of the lowest set bit of a mask.
// ----------------------------------------------------------------------------
module bspa_first_free #(
   parameter int N = 16
) (
   input  wire logic [N-1:0]         free_mask,
   output      logic                 found,
   output      logic [$clog2(N)-1:0] index
);
   localparam int IDX_W = $clog2(N);

   logic [N-1:0] lowest;

   // Two's complement trick isolates the lowest set bit.
   assign lowest = free_mask & (~free_mask + N'(1));
   assign found  = |free_mask;

   always_comb begin
      index = '0;
      for (int i = 0; i < N; i++) begin
         if (lowest[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end
endmodule
`default_nettype wire

// ----- rtl/bspa_pool.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Slot pool state and decision logic
// Holds the in-use marks, the created count and the hit and miss counters,
// and works out the result and next state for one request.
// ----------------------------------------------------------------------------
module bspa_pool
   import bspa_pkg::*;
#(
   parameter int POOL_SLOTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [OP_W-1:0]   operation,
   input  wire logic [SLOT_W-1:0] slot_index,
   output      rsp_type           result
);
   localparam int IDX_W = $clog2(POOL_SLOTS);
   localparam int CNT_W = $clog2(POOL_SLOTS + 1);

   logic [POOL_SLOTS-1:0] busy_ff, busy_in;
   logic [CNT_W-1:0]      created_ff, created_in;
   logic [COUNT_W-1:0]    hits_ff, hits_in;
   logic [COUNT_W-1:0]    misses_ff, misses_in;

   logic [POOL_SLOTS-1:0] created_mask;
   logic [POOL_SLOTS-1:0] free_mask;
   logic                  free_found;
   logic [IDX_W-1:0]      free_index;
   logic                  pool_full;
   logic                  index_known;
   logic [7:0]            index_wide;
   logic [IDX_W-1:0]      return_slot;
   logic [STATUS_W-1:0]   status;
   logic [IDX_W-1:0]      grant_slot;

   always_comb begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
         created_mask[i] = (8'(i) < 8'(created_ff));
      end
   end

   assign free_mask = created_mask & ~busy_ff;

   bspa_first_free #(.N(POOL_SLOTS)) u_first_free (
      .free_mask (free_mask),
      .found     (free_found),
      .index     (free_index)
   );

   assign pool_full   = (created_ff == CNT_W'(POOL_SLOTS));
   assign index_wide  = 8'(slot_index);
   assign index_known = (index_wide < 8'(created_ff));
   assign return_slot = index_wide[IDX_W-1:0];

   always_comb begin
      status     = ST_EXHAUSTED;
      grant_slot = '0;
      busy_in    = busy_ff;
      created_in = created_ff;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      if (operation == OP_GET) begin
         if (free_found) begin
            status     = ST_REUSED;
            grant_slot = free_index;
            hits_in    = hits_ff + COUNT_W'(1);
         end else if (!pool_full) begin
            // Every created slot is busy: grow the pool by one slot.
            status     = ST_NEW;
            grant_slot = created_ff[IDX_W-1:0];
            created_in = created_ff + CNT_W'(1);
            misses_in  = misses_ff + COUNT_W'(1);
         end
         if (status != ST_EXHAUSTED) begin
            busy_in[grant_slot] = 1'b1;
         end
      end else begin
         if (index_known) begin
            status               = ST_RETURNED;
            busy_in[return_slot] = 1'b0;
         end else begin
            status = ST_FOREIGN;
         end
      end
   end

   assign result.status        = status;
   assign result.granted_slot  = SLOT_W'(grant_slot);
   assign result.reuse_count   = hits_in;
   assign result.create_count  = misses_in;
   assign result.slots_created = CREATED_W'(created_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         created_ff <= '0;
         hits_ff    <= '0;
         misses_ff  <= '0;
      end else if (step) begin
         busy_ff    <= busy_in;
         created_ff <= created_in;
         hits_ff    <= hits_in;
         misses_ff  <= misses_in;
      end
   end

   a_created_bounded : assert property (@(posedge clock) disable iff (reset)
      created_ff <= CNT_W'(POOL_SLOTS))
      else $error("created slot count exceeds the pool size");

   a_busy_within_created : assert property (@(posedge clock) disable iff (reset)
      (busy_ff & ~created_mask) == '0)
      else $error("slot marked busy that was never created");

   a_new_grows_pool : assert property (@(posedge clock) disable iff (reset)
      step && status == ST_NEW |=> created_ff == $past(created_ff) + CNT_W'(1))
      else $error("new slot granted without growing the pool");

   a_hits_only_on_reuse : assert property (@(posedge clock) disable iff (reset)
      !(step && status == ST_REUSED) |=> $stable(hits_ff))
      else $error("hit counter moved without a reused slot");

   a_granted_marked_busy : assert property (@(posedge clock) disable iff (reset)
      step && (status == ST_REUSED || status == ST_NEW) |=> busy_ff[$past(grant_slot)])
      else $error("granted slot not marked busy");
endmodule
`default_nettype wire

// ----- rtl/buffer_slot_pool_allocator.sv -----
`default_nettype none
// Path: an accepted request word is held in the input register, then its response
// word is computed and held in the result register until the response channel takes it.
// Throughput: one request per cycle unless the response channel stalls; the lowest free
// slot search is a single priority encoder over the in-use marks between the two registers.
// Reset: synchronous; clears all in-use marks, the created count and both counters at once.
// ----------------------------------------------------------------------------
// Buffer slot pool allocator
// Grow-on-demand allocator of buffer slots with hit and miss counters.
// ----------------------------------------------------------------------------
module buffer_slot_pool_allocator
   import bspa_pkg::*;
#(
   parameter int POOL_SLOTS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   bspa_req_if.sink  req_chan,
   bspa_rsp_if.source rsp_chan
);
   logic              in_valid_ff, in_valid_in;
   logic [OP_W-1:0]   in_op_ff;
   logic [SLOT_W-1:0] in_idx_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_word_ff;

   logic    out_free;
   logic    step;
   logic    accept;
   rsp_type result;

   // The result register can take a new word when empty or being drained.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || step;
   assign accept   = req_chan.valid && req_chan.ready;

   assign in_valid_in  = accept ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   bspa_pool #(.POOL_SLOTS(POOL_SLOTS)) u_pool (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .operation  (in_op_ff),
      .slot_index (in_idx_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff  <= req_chan.operation;
         in_idx_ff <= req_chan.slot_index;
      end
      if (step) begin
         out_word_ff <= result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_word_ff.status;
   assign rsp_chan.granted_slot  = out_word_ff.granted_slot;
   assign rsp_chan.reuse_count   = out_word_ff.reuse_count;
   assign rsp_chan.create_count  = out_word_ff.create_count;
   assign rsp_chan.slots_created = out_word_ff.slots_created;
endmodule
`default_nettype wire
